/* hw/rtl/immediate_and_bit_op_alu_macros.svh */
// ----------------------------------------------------------------------------
// immediate_and_bit_op_alu assertion macros
// Shared concurrent assertion forms for the immediate and bit-op ALU.
// ----------------------------------------------------------------------------
`ifndef IMMEDIATE_AND_BIT_OP_ALU_MACROS_SVH
`define IMMEDIATE_AND_BIT_OP_ALU_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define IABA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define IABA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/iaba_pkg.sv */
// ----------------------------------------------------------------------------
// iaba_pkg
// Types and constants for the immediate and bit-op ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package iaba_pkg;

  // instruction codes
  typedef enum logic [3:0] {
    OP_OR      = 4'd0,
    OP_AND     = 4'd1,
    OP_SUB     = 4'd2,
    OP_ADD     = 4'd3,
    OP_EOR     = 4'd4,
    OP_CMP     = 4'd5,
    OP_OR_CCR  = 4'd6,
    OP_AND_CCR = 4'd7,
    OP_EOR_CCR = 4'd8,
    OP_OR_SR   = 4'd9,
    OP_AND_SR  = 4'd10,
    OP_EOR_SR  = 4'd11,
    OP_BTST    = 4'd12,
    OP_BCHG    = 4'd13,
    OP_BCLR    = 4'd14,
    OP_BSET    = 4'd15
  } opcode_t;

  // operand sizes (any other code is long)
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;

  // status register layout
  localparam int unsigned FLAG_C_BIT = 0;
  localparam int unsigned FLAG_V_BIT = 1;
  localparam int unsigned FLAG_Z_BIT = 2;
  localparam int unsigned FLAG_N_BIT = 3;
  localparam int unsigned FLAG_X_BIT = 4;
  localparam int unsigned FLAG_S_BIT = 13;

  localparam logic [15:0] CCR_MASK  = 16'h001F;
  localparam logic [15:0] SR_MASK   = 16'hF71F;
  localparam logic [15:0] SR_RESET  = 16'h2700;

  // bit number wrap for register and memory targets
  localparam logic [4:0] REG_BIT_MOD = 5'd31;
  localparam logic [4:0] MEM_BIT_MOD = 5'd7;

  // one input transaction
  typedef struct packed {
    opcode_t     opcode;
    logic [1:0]  size;
    logic [31:0] operand;
    logic [31:0] immediate;
    logic [7:0]  bit_number;
    logic        target_is_register;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic [31:0] result_value;
    logic        write_back;
    logic [15:0] status_after;
    logic        privilege_violation;
    logic [15:0] changed_sr_bits;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/immediate_and_bit_op_alu.sv */
// Throughput: one transaction per cycle unless out_stall holds a full result
// register; the status register feedback closes within the single execute pass
// between the input and result registers.
// Reset: synchronous active-low rst_n clears both stage valids and loads the
// status register with 0x2700 (supervisor, interrupt mask 7).
// ----------------------------------------------------------------------------
// immediate_and_bit_op_alu
// Top level: input register, execute pass, result register and status register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "immediate_and_bit_op_alu_macros.svh"

module immediate_and_bit_op_alu (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_opcode,
  input  wire logic [1:0]  in_size,
  input  wire logic [31:0] in_operand,
  input  wire logic [31:0] in_immediate,
  input  wire logic [7:0]  in_bit_number,
  input  wire logic        in_target_is_register,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_result_value,
  output logic             out_write_back,
  output logic [15:0]      out_status_after,
  output logic             out_privilege_violation,
  output logic [15:0]      out_changed_sr_bits
);

  logic              s1_valid_r;
  iaba_pkg::item_t   s1_item_r;
  logic              out_valid_r;
  iaba_pkg::result_t out_res_r;
  logic [15:0]       status_r;
  logic [15:0]       status_nxt;
  iaba_pkg::result_t exec_res;
  logic              advance;
  logic              move;
  logic              in_take;

  // handshake control
  assign advance  = ~out_valid_r | ~out_stall;
  assign move     = s1_valid_r & advance;
  assign in_stall = s1_valid_r & ~advance;
  assign in_take  = in_valid & ~in_stall;

  // execute pass
  iaba_exec u_exec (
    .item (s1_item_r),
    .sr   (status_r),
    .res  (exec_res)
  );

  assign status_nxt = move ? exec_res.status_after : status_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= iaba_pkg::SR_RESET;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (move) begin
        s1_valid_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (~out_stall) begin
        out_valid_r <= 1'b0;
      end
      status_r <= status_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.opcode             <= iaba_pkg::opcode_t'(in_opcode);
      s1_item_r.size               <= in_size;
      s1_item_r.operand            <= in_operand;
      s1_item_r.immediate          <= in_immediate;
      s1_item_r.bit_number         <= in_bit_number;
      s1_item_r.target_is_register <= in_target_is_register;
    end
    if (move) begin
      out_res_r <= exec_res;
    end
  end

  // result channel outputs
  assign out_valid               = out_valid_r;
  assign out_result_value        = out_res_r.result_value;
  assign out_write_back          = out_res_r.write_back;
  assign out_status_after        = out_res_r.status_after;
  assign out_privilege_violation = out_res_r.privilege_violation;
  assign out_changed_sr_bits     = out_res_r.changed_sr_bits;

  // checks
  `IABA_ASSERT_NEXT(a_sr_holds_when_idle, clk, rst_n, !move, $stable(status_r), "status changed without a transaction")
  `IABA_ASSERT_NEXT(a_priv_keeps_sr, clk, rst_n, move && exec_res.privilege_violation, status_r == $past(status_r), "refused sr form changed status")
  `IABA_ASSERT_NEXT(a_no_wb_keeps_value, clk, rst_n, move && !exec_res.write_back, out_res_r.result_value == $past(s1_item_r.operand), "result differs from operand without write back")
  `IABA_ASSERT_NOW(a_changed_needs_priv, clk, rst_n, out_valid_r && out_res_r.privilege_violation, out_res_r.changed_sr_bits == 16'd0, "refused sr form reported changed bits")
  `IABA_ASSERT_NOW(a_out_sr_matches, clk, rst_n, out_valid_r, out_res_r.status_after == status_r, "reported status differs from status register")

endmodule

`default_nettype wire

/* hw/rtl/iaba_exec.sv */
// ----------------------------------------------------------------------------
// iaba_exec
// Single-pass execute logic: sized logic/arith ops, ccr/sr ops, bit ops.
// ----------------------------------------------------------------------------
`default_nettype none

module iaba_exec (
  input  wire iaba_pkg::item_t   item,
  input  wire logic [15:0]       sr,
  output iaba_pkg::result_t      res
);

  logic [31:0] msk;
  logic [31:0] sign;
  logic [31:0] a;
  logic [31:0] b;
  logic [32:0] sum;
  logic [32:0] diff;
  logic        add_c;
  logic [31:0] r_add;
  logic [31:0] r_sub;
  logic [31:0] r_log;
  logic        v_add;
  logic        v_sub;
  logic [15:0] ccr_imm;
  logic [15:0] sr_imm;
  logic [4:0]  bit_idx;
  logic [31:0] bit_msk;
  logic [31:0] bit_val;
  logic [31:0] bit_new;
  logic        bit_set;
  logic [15:0] sr_new;
  logic        supervisor;

  // sized zero and sign flags of a result
  function automatic logic [1:0] nz_of(input logic [31:0] r, input logic [31:0] m,
                                       input logic [31:0] s);
    nz_of = {|(r & s), ~|(r & m)};
  endfunction

  // operand size masks
  always_comb begin
    case (item.size)
      iaba_pkg::SIZE_BYTE: begin
        msk  = 32'h0000_00FF;
        sign = 32'h0000_0080;
      end
      iaba_pkg::SIZE_WORD: begin
        msk  = 32'h0000_FFFF;
        sign = 32'h0000_8000;
      end
      default: begin
        msk  = 32'hFFFF_FFFF;
        sign = 32'h8000_0000;
      end
    endcase
  end

  // add, subtract and logic datapath
  always_comb begin
    a    = item.operand & msk;
    b    = item.immediate & msk;
    sum  = {1'b0, a} + {1'b0, b};
    diff = {1'b0, a} - {1'b0, b};
    case (item.size)
      iaba_pkg::SIZE_BYTE: add_c = sum[8];
      iaba_pkg::SIZE_WORD: add_c = sum[16];
      default:             add_c = sum[32];
    endcase
    r_add = sum[31:0] & msk;
    r_sub = diff[31:0] & msk;
    case (item.opcode)
      iaba_pkg::OP_OR:  r_log = a | b;
      iaba_pkg::OP_AND: r_log = a & b;
      default:          r_log = a ^ b;
    endcase
    v_add = |((a ^ r_add) & (b ^ r_add) & sign);
    v_sub = |((a ^ b) & (a ^ r_sub) & sign);
  end

  // bit number select and bit update
  always_comb begin
    if (item.target_is_register) begin
      bit_idx = item.bit_number[4:0] & iaba_pkg::REG_BIT_MOD;
      bit_val = item.operand;
    end else begin
      bit_idx = item.bit_number[4:0] & iaba_pkg::MEM_BIT_MOD;
      bit_val = {24'd0, item.operand[7:0]};
    end
    bit_msk = 32'd1 << bit_idx;
    bit_set = |(bit_val & bit_msk);
    case (item.opcode)
      iaba_pkg::OP_BCHG: bit_new = bit_val ^ bit_msk;
      iaba_pkg::OP_BCLR: bit_new = bit_val & ~bit_msk;
      default:           bit_new = bit_val | bit_msk;
    endcase
  end

  // result and status selection
  always_comb begin
    ccr_imm    = item.immediate[15:0] & iaba_pkg::CCR_MASK;
    sr_imm     = item.immediate[15:0] & iaba_pkg::SR_MASK;
    supervisor = sr[iaba_pkg::FLAG_S_BIT];
    sr_new     = sr;
    res.result_value        = item.operand;
    res.write_back          = 1'b0;
    res.privilege_violation = 1'b0;
    res.changed_sr_bits     = 16'd0;
    case (item.opcode)
      iaba_pkg::OP_OR, iaba_pkg::OP_AND, iaba_pkg::OP_EOR: begin
        sr_new           = {sr[15:4], nz_of(r_log, msk, sign), 2'b00};
        res.write_back   = 1'b1;
        res.result_value = (item.operand & ~msk) | r_log;
      end
      iaba_pkg::OP_ADD: begin
        sr_new           = {sr[15:5], add_c, nz_of(r_add, msk, sign), v_add, add_c};
        res.write_back   = 1'b1;
        res.result_value = (item.operand & ~msk) | r_add;
      end
      iaba_pkg::OP_SUB: begin
        sr_new           = {sr[15:5], diff[32], nz_of(r_sub, msk, sign), v_sub, diff[32]};
        res.write_back   = 1'b1;
        res.result_value = (item.operand & ~msk) | r_sub;
      end
      iaba_pkg::OP_CMP: begin
        sr_new = {sr[15:4], nz_of(r_sub, msk, sign), v_sub, diff[32]};
      end
      iaba_pkg::OP_OR_CCR:  sr_new = sr | ccr_imm;
      iaba_pkg::OP_AND_CCR: sr_new = sr & (ccr_imm | ~iaba_pkg::CCR_MASK);
      iaba_pkg::OP_EOR_CCR: sr_new = sr ^ ccr_imm;
      iaba_pkg::OP_OR_SR, iaba_pkg::OP_AND_SR, iaba_pkg::OP_EOR_SR: begin
        if (supervisor) begin
          case (item.opcode)
            iaba_pkg::OP_OR_SR:  sr_new = sr | sr_imm;
            iaba_pkg::OP_AND_SR: sr_new = sr & sr_imm;
            default:             sr_new = sr ^ sr_imm;
          endcase
          res.changed_sr_bits = sr ^ sr_new;
        end else begin
          res.privilege_violation = 1'b1;
        end
      end
      iaba_pkg::OP_BTST: begin
        sr_new[iaba_pkg::FLAG_Z_BIT] = ~bit_set;
      end
      iaba_pkg::OP_BCHG, iaba_pkg::OP_BCLR, iaba_pkg::OP_BSET: begin
        sr_new[iaba_pkg::FLAG_Z_BIT] = ~bit_set;
        res.write_back = 1'b1;
        if (item.target_is_register) begin
          res.result_value = bit_new;
        end else begin
          res.result_value = {item.operand[31:8], bit_new[7:0]};
        end
      end
      default: begin
        sr_new = sr;
      end
    endcase
    res.status_after = sr_new;
  end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the immediate and bit-op ALU. Queued instructions are
// pushed through the input channel with random gaps. A local execute model
// predicts each result and tracks the status register. Results are taken with
// random stalls and checked field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  // size codes the package leaves implicit
  localparam logic [1:0] SIZE_LONG     = 2'd2;
  localparam logic [1:0] SIZE_LONG_ALT = 2'd3;

  localparam logic [15:0] NZVC_MASK =
    iaba_pkg::CCR_MASK & ~(16'h1 << iaba_pkg::FLAG_X_BIT);

  localparam int CYCLE_LIMIT   = 200000;
  localparam int QUIET_START   = 1500;
  localparam int QUIET_END     = 2300;
  localparam int IDLE_PERCENT  = 35;
  localparam int DRAIN_CYCLES  = 6;

  logic        clk;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_opcode = '0;
  logic [1:0]  in_size = '0;
  logic [31:0] in_operand = '0;
  logic [31:0] in_immediate = '0;
  logic [7:0]  in_bit_number = '0;
  logic        in_target_is_register = 1'b0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_result_value;
  logic        out_write_back;
  logic [15:0] out_status_after;
  logic        out_privilege_violation;
  logic [15:0] out_changed_sr_bits;

  iaba_pkg::item_t   pending_instrs[$];
  iaba_pkg::result_t expected_results[$];
  iaba_pkg::item_t   cur_instr;
  logic [15:0]       model_sr = iaba_pkg::SR_RESET;
  int                error_count = 0;
  int                cycle_count = 0;

  immediate_and_bit_op_alu u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_opcode               (in_opcode),
    .in_size                 (in_size),
    .in_operand              (in_operand),
    .in_immediate            (in_immediate),
    .in_bit_number           (in_bit_number),
    .in_target_is_register   (in_target_is_register),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_result_value        (out_result_value),
    .out_write_back          (out_write_back),
    .out_status_after        (out_status_after),
    .out_privilege_violation (out_privilege_violation),
    .out_changed_sr_bits     (out_changed_sr_bits)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // n and z from the sized result
  function automatic logic [15:0] nz_of(input logic [31:0] r, input logic [31:0] mask,
                                        input logic [31:0] sign);
    logic [15:0] f;
    f = '0;
    f[iaba_pkg::FLAG_Z_BIT] = ((r & mask) == 32'h0);
    f[iaba_pkg::FLAG_N_BIT] = ((r & sign) != 32'h0);
    return f;
  endfunction

  // execute one instruction against the tracked status register
  function iaba_pkg::result_t execute_instr(input iaba_pkg::item_t it);
    iaba_pkg::result_t res;
    logic [31:0] mask, sign, a, b, r, bm, val, nv;
    logic [32:0] sum;
    logic [15:0] old_sr, flags, ci, si;
    mask = (it.size == iaba_pkg::SIZE_BYTE) ? 32'h0000_00FF :
           (it.size == iaba_pkg::SIZE_WORD) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
    sign = (mask >> 1) + 32'h1;
    a = it.operand & mask;
    b = it.immediate & mask;
    res = '0;
    res.result_value = it.operand;
    old_sr = model_sr;
    ci = it.immediate[15:0] & iaba_pkg::CCR_MASK;
    si = it.immediate[15:0] & iaba_pkg::SR_MASK;
    case (it.opcode)
      iaba_pkg::OP_OR, iaba_pkg::OP_AND, iaba_pkg::OP_EOR: begin
        r = (it.opcode == iaba_pkg::OP_OR) ? (a | b) :
            (it.opcode == iaba_pkg::OP_AND) ? (a & b) : (a ^ b);
        model_sr = (model_sr & ~NZVC_MASK) | nz_of(r, mask, sign);
        res.write_back = 1'b1;
        res.result_value = (it.operand & ~mask) | r;
      end
      iaba_pkg::OP_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        r = sum[31:0] & mask;
        flags = nz_of(r, mask, sign);
        flags[iaba_pkg::FLAG_C_BIT] = (sum > {1'b0, mask});
        flags[iaba_pkg::FLAG_X_BIT] = flags[iaba_pkg::FLAG_C_BIT];
        flags[iaba_pkg::FLAG_V_BIT] = (((a ^ r) & (b ^ r) & sign) != 32'h0);
        model_sr = (model_sr & ~iaba_pkg::CCR_MASK) | flags;
        res.write_back = 1'b1;
        res.result_value = (it.operand & ~mask) | r;
      end
      iaba_pkg::OP_SUB, iaba_pkg::OP_CMP: begin
        r = (a - b) & mask;
        flags = nz_of(r, mask, sign);
        flags[iaba_pkg::FLAG_C_BIT] = (b > a);
        flags[iaba_pkg::FLAG_V_BIT] = (((a ^ b) & (a ^ r) & sign) != 32'h0);
        if (it.opcode == iaba_pkg::OP_SUB) begin
          flags[iaba_pkg::FLAG_X_BIT] = flags[iaba_pkg::FLAG_C_BIT];
          model_sr = (model_sr & ~iaba_pkg::CCR_MASK) | flags;
          res.write_back = 1'b1;
          res.result_value = (it.operand & ~mask) | r;
        end else begin
          // compare leaves x alone
          model_sr = (model_sr & ~NZVC_MASK) | flags;
        end
      end
      iaba_pkg::OP_OR_CCR:  model_sr = model_sr | ci;
      iaba_pkg::OP_AND_CCR: model_sr = (model_sr & ~iaba_pkg::CCR_MASK) | (model_sr & ci);
      iaba_pkg::OP_EOR_CCR: model_sr = model_sr ^ ci;
      iaba_pkg::OP_OR_SR, iaba_pkg::OP_AND_SR, iaba_pkg::OP_EOR_SR: begin
        // whole status register needs supervisor mode
        if (model_sr[iaba_pkg::FLAG_S_BIT]) begin
          if (it.opcode == iaba_pkg::OP_OR_SR) model_sr = model_sr | si;
          else if (it.opcode == iaba_pkg::OP_AND_SR) model_sr = model_sr & si;
          else model_sr = model_sr ^ si;
          res.changed_sr_bits = old_sr ^ model_sr;
        end else begin
          res.privilege_violation = 1'b1;
        end
      end
      default: begin
        // bit test/change/clear/set, register wraps at 32, memory byte at 8
        if (it.target_is_register) begin
          bm = 32'h1 << (it.bit_number[4:0] & iaba_pkg::REG_BIT_MOD);
          val = it.operand;
        end else begin
          bm = 32'h1 << (it.bit_number[4:0] & iaba_pkg::MEM_BIT_MOD);
          val = it.operand & 32'h0000_00FF;
        end
        model_sr[iaba_pkg::FLAG_Z_BIT] = ((val & bm) == 32'h0);
        if (it.opcode == iaba_pkg::OP_BCHG) nv = val ^ bm;
        else if (it.opcode == iaba_pkg::OP_BCLR) nv = val & ~bm;
        else nv = val | bm;
        if (it.opcode != iaba_pkg::OP_BTST) begin
          res.write_back = 1'b1;
          res.result_value = it.target_is_register ? nv : {it.operand[31:8], nv[7:0]};
        end
      end
    endcase
    res.status_after = model_sr;
    return res;
  endfunction

  // random idling, none inside the quiet window
  function bit idle_now();
    if (cycle_count >= QUIET_START && cycle_count < QUIET_END) return 1'b0;
    return ($urandom_range(0, 99) < IDLE_PERCENT);
  endfunction

  // operand values biased toward sign and carry boundaries
  function logic [31:0] pick_value();
    logic [31:0] one_hot;
    one_hot = 32'h1 << $urandom_range(0, 31);
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return one_hot;
      3: return one_hot - 32'h1;
      4: return ~one_hot;
      default: return $urandom;
    endcase
  endfunction

  task push_instr(input iaba_pkg::opcode_t op, input logic [1:0] sz,
                  input logic [31:0] opnd, input logic [31:0] imm,
                  input logic [7:0] bitn, input logic to_reg);
    iaba_pkg::item_t it;
    it.opcode = op;
    it.size = sz;
    it.operand = opnd;
    it.immediate = imm;
    it.bit_number = bitn;
    it.target_is_register = to_reg;
    pending_instrs.push_back(it);
  endtask

  // random instructions; keep_super holds the supervisor bit through sr forms
  task push_random(input int count, input bit keep_super);
    iaba_pkg::item_t it;
    for (int i = 0; i < count; i++) begin
      it.opcode = iaba_pkg::opcode_t'(4'($urandom_range(0, 15)));
      it.size = 2'($urandom_range(0, 3));
      it.operand = pick_value();
      it.immediate = pick_value();
      it.bit_number = 8'($urandom_range(0, 255));
      it.target_is_register = 1'($urandom_range(0, 1));
      if (keep_super) begin
        if (it.opcode == iaba_pkg::OP_AND_SR) it.immediate[iaba_pkg::FLAG_S_BIT] = 1'b1;
        if (it.opcode == iaba_pkg::OP_EOR_SR) it.immediate[iaba_pkg::FLAG_S_BIT] = 1'b0;
      end
      pending_instrs.push_back(it);
    end
  endtask

  task check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      model_sr = iaba_pkg::SR_RESET;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(execute_instr(cur_instr));
      end
      // a stalled transaction is held as is
      if (!in_valid || !in_stall) begin
        if (pending_instrs.size() != 0 && !idle_now()) begin
          cur_instr = pending_instrs.pop_front();
          in_opcode <= cur_instr.opcode;
          in_size <= cur_instr.size;
          in_operand <= cur_instr.operand;
          in_immediate <= cur_instr.immediate;
          in_bit_number <= cur_instr.bit_number;
          in_target_is_register <= cur_instr.target_is_register;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    iaba_pkg::result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %h",
                   $time, out_result_value);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_value", want.result_value, out_result_value);
          check_field("write_back", 32'(want.write_back), 32'(out_write_back));
          check_field("status_after", 32'(want.status_after), 32'(out_status_after));
          check_field("privilege_violation", 32'(want.privilege_violation),
                      32'(out_privilege_violation));
          check_field("changed_sr_bits", 32'(want.changed_sr_bits),
                      32'(out_changed_sr_bits));
        end
      end
      out_stall <= idle_now();
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    // sized arithmetic edges, supervisor mode
    push_instr(iaba_pkg::OP_ADD, iaba_pkg::SIZE_BYTE, 32'hA5A5_A57F, 32'h0000_0001,
               8'h00, 1'b0);
    push_instr(iaba_pkg::OP_ADD, iaba_pkg::SIZE_WORD, 32'h0000_FFFF, 32'h0000_0001,
               8'h00, 1'b0);
    push_instr(iaba_pkg::OP_ADD, SIZE_LONG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 1'b0);
    push_instr(iaba_pkg::OP_SUB, iaba_pkg::SIZE_BYTE, 32'h1234_5600, 32'h0000_0001,
               8'h00, 1'b0);
    push_instr(iaba_pkg::OP_SUB, SIZE_LONG, 32'h8000_0000, 32'h0000_0001, 8'h00, 1'b0);
    push_instr(iaba_pkg::OP_CMP, iaba_pkg::SIZE_WORD, 32'hFFFF_1234, 32'h0000_1234,
               8'h00, 1'b0);
    push_instr(iaba_pkg::OP_CMP, SIZE_LONG_ALT, 32'h0000_0000, 32'h0000_0001, 8'h00, 1'b0);
    // logic ops
    push_instr(iaba_pkg::OP_OR,  iaba_pkg::SIZE_BYTE, 32'hFFFF_FF00, 32'hFFFF_FF00,
               8'h00, 1'b0);
    push_instr(iaba_pkg::OP_AND, iaba_pkg::SIZE_WORD, 32'h0000_FFFF, 32'h0000_8000,
               8'h00, 1'b0);
    push_instr(iaba_pkg::OP_EOR, SIZE_LONG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 1'b0);
    // condition code byte forms
    push_instr(iaba_pkg::OP_OR_CCR,  iaba_pkg::SIZE_BYTE, 32'h0, 32'hFFFF_FFFF, 8'h00, 1'b0);
    push_instr(iaba_pkg::OP_AND_CCR, iaba_pkg::SIZE_BYTE, 32'h0, 32'h0000_0000, 8'h00, 1'b0);
    push_instr(iaba_pkg::OP_EOR_CCR, iaba_pkg::SIZE_BYTE, 32'h0, 32'h0000_0015, 8'h00, 1'b0);
    // full status register forms with supervisor set
    push_instr(iaba_pkg::OP_OR_SR,  iaba_pkg::SIZE_WORD, 32'h0, 32'hFFFF_FFFF, 8'h00, 1'b0);
    push_instr(iaba_pkg::OP_AND_SR, iaba_pkg::SIZE_WORD, 32'h0, 32'h0000_2000, 8'h00, 1'b0);
    push_instr(iaba_pkg::OP_EOR_SR, iaba_pkg::SIZE_WORD, 32'h0, 32'h0000_071F, 8'h00, 1'b0);
    // bit ops, both wrap widths
    push_instr(iaba_pkg::OP_BTST, iaba_pkg::SIZE_BYTE, 32'h8000_0000, 32'h0, 8'd31,  1'b1);
    push_instr(iaba_pkg::OP_BTST, iaba_pkg::SIZE_BYTE, 32'hFFFF_FF00, 32'h0, 8'd255, 1'b0);
    push_instr(iaba_pkg::OP_BCHG, iaba_pkg::SIZE_BYTE, 32'h0000_0000, 32'h0, 8'd32,  1'b1);
    push_instr(iaba_pkg::OP_BCLR, iaba_pkg::SIZE_BYTE, 32'hFFFF_FFFF, 32'h0, 8'd11,  1'b0);
    push_instr(iaba_pkg::OP_BSET, iaba_pkg::SIZE_BYTE, 32'h0000_0000, 32'h0, 8'd255, 1'b1);
    push_instr(iaba_pkg::OP_BSET, iaba_pkg::SIZE_BYTE, 32'hFFFF_FF00, 32'h0, 8'd8,   1'b0);
    push_random(1450, 1'b1);
    // drop to user mode, then sr forms are refused
    push_instr(iaba_pkg::OP_AND_SR, iaba_pkg::SIZE_WORD, 32'h0, 32'h0000_0000, 8'h00, 1'b0);
    push_instr(iaba_pkg::OP_OR_SR,  iaba_pkg::SIZE_WORD, 32'h0, 32'hFFFF_FFFF, 8'h00, 1'b0);
    push_instr(iaba_pkg::OP_EOR_SR, iaba_pkg::SIZE_WORD, 32'h0, 32'h0000_2000, 8'h00, 1'b0);
    push_instr(iaba_pkg::OP_AND_SR, iaba_pkg::SIZE_WORD, 32'h0, 32'hFFFF_FFFF, 8'h00, 1'b0);
    push_instr(iaba_pkg::OP_OR_CCR, iaba_pkg::SIZE_BYTE, 32'h0, 32'h0000_001F, 8'h00, 1'b0);
    push_random(100, 1'b0);

    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // drain, sampled away from the active edge
    @(negedge clk);
    while (pending_instrs.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/iaba_pkg.sv
hw/rtl/iaba_exec.sv
hw/rtl/immediate_and_bit_op_alu.sv
tb/sv/testbench.sv
